// File: rtl/sida_pkg.sv
// Shared constants for the signed integer to decimal ASCII converter.
`timescale 1ns / 1ps
`default_nettype none

package sida_pkg;

    localparam int VALUE_W    = 32;
    localparam int NUM_DIGITS = 10;
    localparam int BCD_W      = 4 * NUM_DIGITS;
    localparam int CNT_W      = $clog2(VALUE_W + 1);
    localparam int CHAR_W     = 6;
    localparam int TDATA_W    = 8;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;

    // converter handshake toward the control logic
    typedef struct packed {
        logic                 done;
        logic [BCD_W-1:0]     bcd;
    } dab_result_t;

endpackage : sida_pkg

`default_nettype wire

// File: rtl/sida_dabble.sv
// Bit-serial binary to BCD converter (shift and add 3), one input bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module sida_dabble (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [sida_pkg::VALUE_W-1:0]  mag,
    output sida_pkg::dab_result_t              result
);
    import sida_pkg::*;

    logic [VALUE_W-1:0] bin_reg, bin_next;
    logic [BCD_W-1:0]   bcd_reg, bcd_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               done_reg, done_next;
    logic [BCD_W-1:0]   bcd_adj;
    logic               busy;

    assign busy = (cnt_reg != '0);

    // each digit of 5 or more gets 3 added before the shift
    always_comb begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (bcd_reg[4*i +: 4] >= 4'd5) begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end else begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    always_comb begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start) begin
            bin_next = mag;
            bcd_next = '0;
            cnt_next = CNT_W'(VALUE_W);
        end else if (busy) begin
            bin_next  = {bin_reg[VALUE_W-2:0], 1'b0};
            bcd_next  = {bcd_adj[BCD_W-2:0], bin_reg[VALUE_W-1]};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign result.done = done_reg;
    assign result.bcd  = bcd_reg;

endmodule : sida_dabble

`default_nettype wire

// File: rtl/signed_int_to_decimal_ascii.sv
// Top level: signed 32-bit integer to a run of decimal ASCII characters.
//
// Input stream: s_tdata carries one two's complement value per request.
// Output stream: one ASCII character per request on m_tdata, m_tlast set on
// the final character of each number's text. A negative value starts with
// '-'; digits follow most significant first with no leading zeros, zero
// gives a single '0'. The most negative value converts exactly.
// Timing: after a request is taken, the converter runs its bit-serial
// shift-and-add-3 loop, the digits are captured, then one character per cycle
// goes out while the receiver takes them; the block works on one item at a time.
// s_tready is high only while no conversion or emission is under way; it
// rises again once the final character is in the output register, even if
// that character still waits for the receiver.
// A receiver stall simply holds the output register; no data is dropped.
// Reset (aresetn low, synchronous) drops any item in flight and clears the
// output valid.
`timescale 1ns / 1ps
`default_nettype none

module signed_int_to_decimal_ascii (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_tvalid,
    output      logic                                 s_tready,
    input  wire logic signed [sida_pkg::VALUE_W-1:0]  s_tdata,  // [31:0] value
    output      logic                                 m_tvalid,
    input  wire logic                                 m_tready,
    output      logic [sida_pkg::TDATA_W-1:0]         m_tdata,  // [5:0] character, [7:6] zero
    output      logic                                 m_tlast   // last
);
    import sida_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CONV = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic               neg_reg, neg_next;
    logic [3:0]         idx_reg, idx_next;
    logic [BCD_W-1:0]   digits_reg, digits_next;
    logic [CHAR_W-1:0]  char_reg, char_next;
    logic               last_reg, last_next;
    logic               mvalid_reg, mvalid_next;

    logic               s_accept;
    logic               out_free;
    logic [VALUE_W-1:0] raw;
    logic [VALUE_W-1:0] mag;
    logic [3:0]         top_idx;
    logic [3:0]         cur_digit;
    dab_result_t        dab;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !mvalid_reg || m_tready;

    assign raw = VALUE_W'(s_tdata);
    assign mag = raw[VALUE_W-1] ? (~raw + 1'b1) : raw;

    sida_dabble u_dabble (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (s_accept),
        .mag     (mag),
        .result  (dab)
    );

    // position of the most significant nonzero digit, 0 when all are zero
    always_comb begin
        top_idx = '0;
        for (int i = 1; i < NUM_DIGITS; i++) begin
            if (dab.bcd[4*i +: 4] != 4'd0) begin
                top_idx = 4'(i);
            end
        end
    end

    always_comb begin
        cur_digit = '0;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (idx_reg == 4'(i)) begin
                cur_digit = digits_reg[4*i +: 4];
            end
        end
    end

    always_comb begin
        state_next  = state_reg;
        neg_next    = neg_reg;
        idx_next    = idx_reg;
        digits_next = digits_reg;
        char_next   = char_reg;
        last_next   = last_reg;
        mvalid_next = mvalid_reg;

        if (mvalid_reg && m_tready) begin
            mvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    neg_next   = raw[VALUE_W-1];
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                if (dab.done) begin
                    digits_next = dab.bcd;
                    idx_next    = top_idx;
                    state_next  = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    mvalid_next = 1'b1;
                    if (neg_reg) begin
                        char_next = CHAR_MINUS;
                        last_next = 1'b0;
                        neg_next  = 1'b0;
                    end else begin
                        char_next = CHAR_ZERO + CHAR_W'(cur_digit);
                        last_next = (idx_reg == 4'd0);
                        if (idx_reg == 4'd0) begin
                            state_next = ST_IDLE;
                        end else begin
                            idx_next = idx_reg - 1'b1;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
        end
        neg_reg    <= neg_next;
        idx_reg    <= idx_next;
        digits_reg <= digits_next;
        char_reg   <= char_next;
        last_reg   <= last_next;
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = {(TDATA_W - CHAR_W)'(0), char_reg};
    assign m_tlast  = last_reg;

endmodule : signed_int_to_decimal_ascii

`default_nettype wire

// File: rtl/sida_checker.sv
// Port-level checker for the decimal ASCII converter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module sida_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [sida_pkg::TDATA_W-1:0]  m_tdata,
    input wire logic                          m_tlast
);
    import sida_pkg::*;

    localparam logic [TDATA_W-1:0] MINUS_CODE = TDATA_W'(CHAR_MINUS);
    localparam logic [TDATA_W-1:0] ZERO_CODE  = TDATA_W'(CHAR_ZERO);
    localparam logic [TDATA_W-1:0] NINE_CODE  = TDATA_W'(CHAR_ZERO) + TDATA_W'(9);

    // stalled output request holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output request changed while stalled");

    // only '-' or a digit ever leaves the block
    a_char_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata == MINUS_CODE) ||
                     ((m_tdata >= ZERO_CODE) && (m_tdata <= NINE_CODE)))
        else $error("character out of range");

    // the sign never ends a run
    a_minus_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata == MINUS_CODE) |-> !m_tlast)
        else $error("minus sign flagged as last");

    // a taken input starts a conversion, so the input side closes
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after a request");

endmodule : sida_checker

bind signed_int_to_decimal_ascii sida_checker u_sida_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

// File: test/tb.sv
// Testbench for signed_int_to_decimal_ascii: checks each character run against an in-bench predictor.
`timescale 1ns / 1ps

module tb;
    import sida_pkg::*;

    localparam int      HOLD_CYCLES = 400;
    localparam longint  CYCLE_LIMIT = 1_000_000;
    localparam int      TAIL_CYCLES = 60;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              fin;
    } text_char_t;

    logic                      aclk     = 1'b0;
    logic                      aresetn  = 1'b0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic signed [VALUE_W-1:0] s_tdata  = '0;
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [TDATA_W-1:0]        m_tdata;
    logic                      m_tlast;

    logic [VALUE_W-1:0] value_q[$];     // values waiting to be offered
    text_char_t         text_q[$];      // characters still owed by the block
    int                 send_idle_pct  = 0;
    int                 recv_stall_pct = 0;
    int                 err_cnt        = 0;
    longint             cycle_cnt      = 0;
    logic               hold_req       = 1'b0;
    logic               hold_seen      = 1'b0;
    int                 hold_left      = 0;

    signed_int_to_decimal_ascii i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #10 aclk = ~aclk;

    task automatic report_mismatch(input string what);
        if (err_cnt < 40)
            $display("%0t mismatch: %s", $realtime, what);
        err_cnt++;
    endtask

    // Expected text of one value: optional minus, then digits MSD first.
    function automatic void predict_text(input logic [VALUE_W-1:0] raw);
        logic [VALUE_W-1:0] mag;
        logic [3:0]         digs[NUM_DIGITS];
        int                 nd;
        text_char_t         c;
        nd  = 0;
        mag = raw[VALUE_W-1] ? -raw : raw;
        do begin
            digs[nd] = mag % 10;
            nd++;
            mag = mag / 10;
        end while (mag != 0 && nd < NUM_DIGITS);
        if (raw[VALUE_W-1]) begin
            c.ch  = CHAR_MINUS;
            c.fin = 1'b0;
            text_q.push_back(c);
        end
        for (int i = nd - 1; i >= 0; i--) begin
            c.ch  = CHAR_ZERO + CHAR_W'(digs[i]);
            c.fin = (i == 0);
            text_q.push_back(c);
        end
    endfunction

    function automatic longint pow10(input int k);
        longint p;
        p = 1;
        repeat (k) p = p * 10;
        return p;
    endfunction

    // Mix of full-range values, values of a chosen digit count, decade
    // boundaries and tiny magnitudes.
    function automatic logic [VALUE_W-1:0] pick_value();
        logic [VALUE_W-1:0] mag;
        logic               neg;
        longint             lo, hi;
        int                 n;
        neg = $urandom_range(1);
        case ($urandom_range(3))
            0: return $urandom;
            1: begin
                n  = $urandom_range(1, NUM_DIGITS);
                lo = (n == 1) ? 0 : pow10(n - 1);
                hi = pow10(n) - 1;
                if (hi > 64'd2147483647)
                    hi = neg ? 64'd2147483648 : 64'd2147483647;
                mag = $urandom_range(VALUE_W'(hi), VALUE_W'(lo));
            end
            2: begin
                n   = $urandom_range(0, NUM_DIGITS - 1);
                mag = VALUE_W'(pow10(n)) - $urandom_range(1) + $urandom_range(1);
            end
            default: mag = $urandom_range(20);
        endcase
        return neg ? -mag : mag;
    endfunction

    // Sender.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (value_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_tdata  <= value_q.pop_front();
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // One long receiver hold-off, armed from the sequence.
    always @(posedge aclk) begin
        if (hold_req && !hold_seen) begin
            hold_seen <= 1'b1;
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Receiver.
    always @(posedge aclk) begin
        if (hold_left != 0)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: check results first, then predict from the accepted request.
    always @(posedge aclk) begin
        text_char_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (text_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected char 0x%0h", m_tdata));
                end else begin
                    want = text_q.pop_front();
                    if (m_tdata[CHAR_W-1:0] !== want.ch)
                        report_mismatch($sformatf("char %0d, want %0d",
                                                  m_tdata[CHAR_W-1:0], want.ch));
                    if (m_tdata[TDATA_W-1:CHAR_W] !== '0)
                        report_mismatch($sformatf("pad bits 0x%0h",
                                                  m_tdata[TDATA_W-1:CHAR_W]));
                    if (m_tlast !== want.fin)
                        report_mismatch($sformatf("tlast %0b, want %0b",
                                                  m_tlast, want.fin));
                end
            end
            if (s_tvalid && s_tready)
                predict_text(s_tdata);
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("[signed_int_to_decimal_ascii] ERROR");
            $finish;
        end
    end

    task automatic drain();
        while (value_q.size() != 0 || s_tvalid || text_q.size() != 0)
            @(negedge aclk);
    endtask

    task automatic run_random(input int count, input int s_pct, input int r_pct);
        send_idle_pct  = s_pct;
        recv_stall_pct = r_pct;
        repeat (count) value_q.push_back(pick_value());
        drain();
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: zero, single digits, decade edges, extremes, bit patterns
        value_q.push_back(32'd0);
        value_q.push_back(32'd1);
        value_q.push_back(-32'sd1);
        value_q.push_back(32'd9);
        value_q.push_back(32'd10);
        value_q.push_back(-32'sd10);
        value_q.push_back(32'd99);
        value_q.push_back(32'd100);
        value_q.push_back(-32'sd9);
        value_q.push_back(32'd999999999);
        value_q.push_back(32'd1000000000);
        value_q.push_back(-32'sd999999999);
        value_q.push_back(-32'sd1000000000);
        value_q.push_back(32'h7FFF_FFFF);
        value_q.push_back(32'h8000_0000);
        value_q.push_back(32'h8000_0001);
        value_q.push_back(32'h5555_5555);
        value_q.push_back(32'hAAAA_AAAA);
        value_q.push_back(32'd0);
        drain();

        run_random(110, 0, 0);
        run_random(110, 62, 0);
        run_random(110, 0, 62);
        run_random(110, 8, 8);

        // receiver holds off while the sender keeps offering
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (20) value_q.push_back(pick_value());
        hold_req = 1'b1;
        drain();

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (text_q.size() != 0)
            report_mismatch($sformatf("%0d chars never arrived", text_q.size()));
        if (err_cnt == 0)
            $display("[signed_int_to_decimal_ascii] OK");
        else
            $display("[signed_int_to_decimal_ascii] ERROR");
        $finish;
    end

endmodule
